>>> rtl/core/gpp_pkg.sv
// Shared types, constants and register codes of the grid partition planner.
package gpp_pkg;

	// Partitions per request at most; the last band or quadrant has index MAX_PARTS-1
	localparam int MAX_PARTS = 4;
	localparam int PART_W = $clog2(MAX_PARTS);
	localparam logic [PART_W-1:0] LAST_PART = PART_W'(MAX_PARTS - 1);

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Request codes that split the grid
	localparam logic [3:0] REQ_TWO = 4'd2;
	localparam logic [3:0] REQ_FOUR = 4'd4;

	// Grid size thresholds
	localparam logic [7:0] SPLIT_MIN = 8'd4;
	localparam logic [7:0] BAND_MIN_ROWS = 8'd8;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CORE_PE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CORE_FU = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CORE_SPM = 3'd4;

	// Reset values of the configuration registers
	localparam logic [7:0] RST_GRID_ROWS = 8'd4;
	localparam logic [7:0] RST_GRID_COLS = 8'd4;
	localparam logic [15:0] RST_CORE_PE = 16'd16;
	localparam logic [15:0] RST_CORE_FU = 16'd16;
	localparam logic [31:0] RST_CORE_SPM = 32'd65536;

	// How a request is carried out
	typedef enum logic [2:0] {
		PM_WHOLE,
		PM_ROW2,
		PM_COL2,
		PM_BAND4,
		PM_QUAD4
	} plan_mode_t;

	// Back sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CALC,
		BK_MUL,
		BK_DIV
	} back_state_t;

	typedef struct packed {
		logic [7:0] grid_rows;
		logic [7:0] grid_cols;
		logic [15:0] core_pe_total;
		logic [15:0] core_fu_total;
		logic [31:0] core_spm_total;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [7:0] row_first;
		logic [7:0] row_limit;
		logic [7:0] col_first;
		logic [7:0] col_limit;
		logic [15:0] pe_share;
		logic [15:0] fu_share;
		logic [31:0] spm_share;
		logic final_part;
	} result_t;

endpackage

>>> rtl/core/gpp_front.sv
// Front end: accepts requests, classifies the split and hands them to the queue.
module gpp_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [3:0] partition_count,
	input gpp_pkg::cfg_t cfg,
	input gpp_pkg::queue_stat_t q_stat,
	output logic busy,
	output logic push,
	output gpp_pkg::plan_mode_t push_mode
);

	gpp_pkg::plan_mode_t mode_c;
	gpp_pkg::plan_mode_t mode_s1;
	logic valid_s1;
	logic accept;

	// Pick the split from the count and the grid size
	always_comb begin
		mode_c = gpp_pkg::PM_WHOLE;
		case (partition_count)
			gpp_pkg::REQ_TWO: begin
				if (cfg.grid_rows >= gpp_pkg::SPLIT_MIN) begin
					mode_c = gpp_pkg::PM_ROW2;
				end else if (cfg.grid_cols >= gpp_pkg::SPLIT_MIN) begin
					mode_c = gpp_pkg::PM_COL2;
				end
			end
			gpp_pkg::REQ_FOUR: begin
				if (cfg.grid_rows >= gpp_pkg::BAND_MIN_ROWS) begin
					mode_c = gpp_pkg::PM_BAND4;
				end else if (cfg.grid_rows >= gpp_pkg::SPLIT_MIN &&
						cfg.grid_cols >= gpp_pkg::SPLIT_MIN) begin
					mode_c = gpp_pkg::PM_QUAD4;
				end
			end
			default: begin
				mode_c = gpp_pkg::PM_WHOLE;
			end
		endcase
	end

	// Stage holds one classified request until the queue has room
	assign busy = valid_s1 && q_stat.full;
	assign accept = start && !busy;
	assign push = valid_s1 && !q_stat.full;
	assign push_mode = mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode_c;
		end
	end

endmodule

>>> rtl/core/gpp_queue.sv
// Small request queue between the front end and the back end.
module gpp_queue #(
	parameter int DEPTH = gpp_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input gpp_pkg::plan_mode_t push_mode,
	input logic pop,
	output gpp_pkg::plan_mode_t pop_mode,
	output gpp_pkg::queue_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gpp_pkg::plan_mode_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign q_stat.full = (cnt_q == CNT_W'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_mode = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_mode;
		end
	end

endmodule

>>> rtl/core/gpp_div.sv
// Iterative radix-4 divider producing both resource shares in lockstep.
module gpp_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] num_fu,
	input logic [47:0] num_spm,
	input logic [15:0] den,
	output logic done,
	output logic [15:0] q_fu,
	output logic [31:0] q_spm
);

	// Two restoring steps; rem stays below den, sh shifts dividend out, quotient in
	function automatic logic [47:0] div_step(input logic [15:0] rem,
			input logic [31:0] sh, input logic [15:0] dv);
		logic [16:0] t1;
		logic [16:0] t2;
		logic [15:0] r1;
		logic [15:0] r2;
		logic ge1;
		logic ge2;
		t1 = {rem, sh[31]};
		ge1 = (t1 >= {1'b0, dv});
		r1 = ge1 ? 16'(t1 - {1'b0, dv}) : t1[15:0];
		t2 = {r1, sh[30]};
		ge2 = (t2 >= {1'b0, dv});
		r2 = ge2 ? 16'(t2 - {1'b0, dv}) : t2[15:0];
		return {r2, sh[29:0], ge1, ge2};
	endfunction

	logic [15:0] den_q;
	logic [15:0] rem_fu_q;
	logic [31:0] sh_fu_q;
	logic [15:0] rem_spm_q;
	logic [31:0] sh_spm_q;
	logic [3:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [47:0] nxt_fu;
	logic [47:0] nxt_spm;

	assign nxt_fu = div_step(rem_fu_q, sh_fu_q, den_q);
	assign nxt_spm = div_step(rem_spm_q, sh_spm_q, den_q);
	assign done = done_q;
	assign q_fu = sh_fu_q[15:0];
	assign q_spm = sh_spm_q;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '1;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Datapath; quotients fit 32 bits so the top dividend word seeds the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_fu_q <= '0;
			sh_fu_q <= num_fu;
			rem_spm_q <= num_spm[47:32];
			sh_spm_q <= num_spm[31:0];
		end else if (busy_q) begin
			rem_fu_q <= nxt_fu[47:32];
			sh_fu_q <= nxt_fu[31:0];
			rem_spm_q <= nxt_spm[47:32];
			sh_spm_q <= nxt_spm[31:0];
		end
	end

endmodule

>>> rtl/core/gpp_back.sv
// Back end: walks the partitions of each queued request and drives the results.
module gpp_back (
	input logic clk,
	input logic arst_n,
	input gpp_pkg::cfg_t cfg,
	input gpp_pkg::queue_stat_t q_stat,
	input gpp_pkg::plan_mode_t q_mode,
	output logic pop,
	output logic res_valid,
	output gpp_pkg::result_t res
);

	gpp_pkg::back_state_t state_q;
	gpp_pkg::back_state_t state_nxt;
	gpp_pkg::plan_mode_t mode_q;
	logic [gpp_pkg::PART_W-1:0] k_q;

	// Partition geometry, registered in CALC
	logic [7:0] rf_c, rl_c, cf_c, cl_c;
	logic [7:0] h_c, w_c, band_c, band_first_c, mid_r_c, mid_c_c;
	logic [15:0] area_c, m_c, den_c;
	logic last_c;
	logic [7:0] rf_q, rl_q, cf_q, cl_q;
	logic [15:0] pe_q, m_q, den_q;
	logic last_q;

	// Divider hookup and saved first-half shares
	logic div_start, div_done;
	logic [31:0] num_fu;
	logic [47:0] num_spm;
	logic [15:0] q_fu;
	logic [31:0] q_spm;
	logic [15:0] fu0_q;
	logic [31:0] spm0_q;

	logic no_div, rem_part, out_load;
	logic res_valid_q;
	gpp_pkg::result_t res_q;

	assign mid_r_c = cfg.grid_rows >> 1;
	assign mid_c_c = cfg.grid_cols >> 1;
	assign band_c = cfg.grid_rows >> 2;

	// Start row of a band
	always_comb begin
		case (k_q)
			2'd0: band_first_c = '0;
			2'd1: band_first_c = band_c;
			2'd2: band_first_c = band_c << 1;
			default: band_first_c = 8'(band_c + (band_c << 1));
		endcase
	end

	// Rectangle of partition k
	always_comb begin
		rf_c = '0;
		rl_c = cfg.grid_rows;
		cf_c = '0;
		cl_c = cfg.grid_cols;
		case (mode_q)
			gpp_pkg::PM_ROW2: begin
				rf_c = k_q[0] ? mid_r_c : '0;
				rl_c = k_q[0] ? cfg.grid_rows : mid_r_c;
			end
			gpp_pkg::PM_COL2: begin
				cf_c = k_q[0] ? mid_c_c : '0;
				cl_c = k_q[0] ? cfg.grid_cols : mid_c_c;
			end
			gpp_pkg::PM_BAND4: begin
				rf_c = band_first_c;
				rl_c = (k_q == gpp_pkg::LAST_PART) ? cfg.grid_rows :
						8'(band_first_c + band_c);
			end
			gpp_pkg::PM_QUAD4: begin
				rf_c = k_q[1] ? mid_r_c : '0;
				rl_c = k_q[1] ? cfg.grid_rows : mid_r_c;
				cf_c = k_q[0] ? mid_c_c : '0;
				cl_c = k_q[0] ? cfg.grid_cols : mid_c_c;
			end
			default: begin
				rf_c = '0;
			end
		endcase
	end

	assign h_c = rl_c - rf_c;
	assign w_c = cl_c - cf_c;
	assign area_c = 16'(h_c) * 16'(w_c);

	// Share multiplier, divisor and last mark
	always_comb begin
		m_c = '0;
		den_c = '0;
		last_c = (k_q == gpp_pkg::LAST_PART);
		case (mode_q)
			gpp_pkg::PM_ROW2: begin
				m_c = {8'd0, h_c};
				den_c = {8'd0, cfg.grid_rows};
				last_c = k_q[0];
			end
			gpp_pkg::PM_COL2: begin
				m_c = {8'd0, w_c};
				den_c = {8'd0, cfg.grid_cols};
				last_c = k_q[0];
			end
			gpp_pkg::PM_BAND4: begin
				m_c = {8'd0, h_c};
				den_c = {8'd0, cfg.grid_rows};
			end
			gpp_pkg::PM_QUAD4: begin
				m_c = area_c;
				den_c = 16'(cfg.grid_rows) * 16'(cfg.grid_cols);
			end
			default: begin
				last_c = 1'b1;
			end
		endcase
	end

	// Second half of a two-way split takes the remainder, no division
	assign rem_part = (mode_q == gpp_pkg::PM_ROW2 || mode_q == gpp_pkg::PM_COL2) &&
			k_q[0];
	assign no_div = (mode_q == gpp_pkg::PM_WHOLE) || rem_part;

	assign num_fu = 32'(cfg.core_fu_total) * 32'(m_q);
	assign num_spm = 48'(cfg.core_spm_total) * 48'(m_q);

	gpp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num_fu(num_fu),
		.num_spm(num_spm),
		.den(den_q),
		.done(div_done),
		.q_fu(q_fu),
		.q_spm(q_spm)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gpp_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					state_nxt = gpp_pkg::BK_CALC;
				end
			end
			gpp_pkg::BK_CALC: begin
				state_nxt = gpp_pkg::BK_MUL;
			end
			gpp_pkg::BK_MUL: begin
				if (!no_div) begin
					state_nxt = gpp_pkg::BK_DIV;
				end else if (last_q) begin
					state_nxt = gpp_pkg::BK_IDLE;
				end else begin
					state_nxt = gpp_pkg::BK_CALC;
				end
			end
			gpp_pkg::BK_DIV: begin
				if (div_done) begin
					state_nxt = last_q ? gpp_pkg::BK_IDLE : gpp_pkg::BK_CALC;
				end
			end
			default: begin
				state_nxt = gpp_pkg::BK_IDLE;
			end
		endcase
	end

	// Control outputs
	always_comb begin
		pop = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			gpp_pkg::BK_IDLE: begin
				pop = !q_stat.empty;
			end
			gpp_pkg::BK_MUL: begin
				div_start = !no_div;
				out_load = no_div;
			end
			gpp_pkg::BK_DIV: begin
				out_load = div_done;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gpp_pkg::BK_IDLE;
			k_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			res_valid_q <= out_load;
			if (pop) begin
				k_q <= '0;
			end else if (out_load && !last_q) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			mode_q <= q_mode;
		end
		if (state_q == gpp_pkg::BK_CALC) begin
			rf_q <= rf_c;
			rl_q <= rl_c;
			cf_q <= cf_c;
			cl_q <= cl_c;
			pe_q <= area_c;
			m_q <= m_c;
			den_q <= den_c;
			last_q <= last_c;
		end
		if (div_done && k_q == '0) begin
			fu0_q <= q_fu;
			spm0_q <= q_spm;
		end
		if (out_load) begin
			res_q.row_first <= rf_q;
			res_q.row_limit <= rl_q;
			res_q.col_first <= cf_q;
			res_q.col_limit <= cl_q;
			res_q.final_part <= last_q;
			if (mode_q == gpp_pkg::PM_WHOLE) begin
				res_q.pe_share <= cfg.core_pe_total;
				res_q.fu_share <= cfg.core_fu_total;
				res_q.spm_share <= cfg.core_spm_total;
			end else if (rem_part) begin
				res_q.pe_share <= pe_q;
				res_q.fu_share <= cfg.core_fu_total - fu0_q;
				res_q.spm_share <= cfg.core_spm_total - spm0_q;
			end else begin
				res_q.pe_share <= pe_q;
				res_q.fu_share <= q_fu;
				res_q.spm_share <= q_spm;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

>>> rtl/core/grid_partition_planner.sv
// A whole-grid request passes IDLE, CALC and MUL in the back sequencer and is then strobed from a register.
// A divided partition also waits in DIV for the 16-step radix-4 divider;
// the remainder half of a two-way split follows the first half with no division.
// New requests are taken into the front stage and the queue while the back end is still busy.
// Reset clears the queue, the sequencer and the strobe; registers return to defaults.
// Results are strobed for one cycle and the receiver cannot stall them.
module grid_partition_planner #(
	parameter int QUEUE_DEPTH = gpp_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [gpp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic start,
	output logic busy,
	input logic [3:0] partition_count,
	output logic valid,
	output logic [7:0] row_first,
	output logic [7:0] row_limit,
	output logic [7:0] col_first,
	output logic [7:0] col_limit,
	output logic [15:0] pe_share,
	output logic [15:0] fu_share,
	output logic [31:0] spm_share,
	output logic final_part
);

	gpp_pkg::cfg_t cfg_q;
	gpp_pkg::queue_stat_t q_stat;
	gpp_pkg::plan_mode_t push_mode;
	gpp_pkg::plan_mode_t pop_mode;
	gpp_pkg::result_t res;
	logic q_push;
	logic q_pop;

	// Configuration registers; writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_rows <= gpp_pkg::RST_GRID_ROWS;
			cfg_q.grid_cols <= gpp_pkg::RST_GRID_COLS;
			cfg_q.core_pe_total <= gpp_pkg::RST_CORE_PE;
			cfg_q.core_fu_total <= gpp_pkg::RST_CORE_FU;
			cfg_q.core_spm_total <= gpp_pkg::RST_CORE_SPM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gpp_pkg::CFG_GRID_ROWS: cfg_q.grid_rows <= cfg_data[7:0];
				gpp_pkg::CFG_GRID_COLS: cfg_q.grid_cols <= cfg_data[7:0];
				gpp_pkg::CFG_CORE_PE: cfg_q.core_pe_total <= cfg_data[15:0];
				gpp_pkg::CFG_CORE_FU: cfg_q.core_fu_total <= cfg_data[15:0];
				gpp_pkg::CFG_CORE_SPM: cfg_q.core_spm_total <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	gpp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.partition_count(partition_count),
		.cfg(cfg_q),
		.q_stat(q_stat),
		.busy(busy),
		.push(q_push),
		.push_mode(push_mode)
	);

	gpp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_mode(push_mode),
		.pop(q_pop),
		.pop_mode(pop_mode),
		.q_stat(q_stat)
	);

	gpp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_stat(q_stat),
		.q_mode(pop_mode),
		.pop(q_pop),
		.res_valid(valid),
		.res(res)
	);

	assign row_first = res.row_first;
	assign row_limit = res.row_limit;
	assign col_first = res.col_first;
	assign col_limit = res.col_limit;
	assign pe_share = res.pe_share;
	assign fu_share = res.fu_share;
	assign spm_share = res.spm_share;
	assign final_part = res.final_part;

	// Queue never written when full, never read when empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
			q_push |-> !q_stat.full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
			q_pop |-> !q_stat.empty) else $error("queue pop while empty");
	// Front stalls only on a full queue
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
			busy |-> q_stat.full) else $error("busy without full queue");
	// Each partition passes CALC and MUL in the sequencer, so result strobes never come back to back
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
			valid |=> !valid) else $error("result strobe on consecutive cycles");

endmodule
